>>> rtl/esht_pkg.sv
// ----------------------------------------------------------------------------
// esht_pkg
// types, widths and codes shared by the ellipse hit test pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package esht_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int MAG_W       = COORD_WIDTH;
  localparam int LEN_W       = 2 * COORD_WIDTH + 1;
  localparam int DOT_W       = 2 * COORD_WIDTH + 2;
  localparam int REM_W       = LEN_W + 3;
  localparam int PROD_W      = 2 * COORD_WIDTH;
  localparam int SQ_W        = 4 * COORD_WIDTH;
  localparam int REG_IDX_W   = 3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [COORD_WIDTH-2:0]        radius_t;
  typedef logic signed [COORD_WIDTH:0]   diff_t;
  typedef logic [MAG_W-1:0]              mag_t;
  typedef logic [LEN_W-1:0]              len_t;
  typedef logic signed [DOT_W-1:0]       dot_t;
  typedef logic [LEN_W:0]                den_t;
  typedef logic [REM_W-1:0]              rem_t;
  typedef logic [PROD_W-1:0]             prod_t;
  typedef logic [SQ_W-1:0]               sq_t;

  localparam radius_t MIN_LEN_RESET = radius_t'(1638);

  typedef enum logic [1:0] {
    SEL_FIRST  = 2'd0,
    SEL_SECOND = 2'd1,
    SEL_INTERP = 2'd2
  } sel_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_RADIUS_X = 3'd2,
    REG_RADIUS_Y = 3'd3,
    REG_MIN_LEN  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    coord_t  center_x;
    coord_t  center_y;
    radius_t radius_x;
    radius_t radius_y;
    radius_t min_len;
  } cfg_t;

  typedef struct packed {
    rem_t   rem;
    mag_t   quo;
    mag_t   mag;
    logic   neg;
    coord_t first;
    coord_t second;
  } lane_t;

  typedef struct packed {
    logic       valid;
    sel_t       sel;
    den_t       den;
    den_t       num;
    lane_t [1:0] lane;
  } div_item_t;

  typedef struct packed {
    logic   valid;
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    logic   hit;
    coord_t x;
    coord_t y;
  } out_t;

  typedef struct packed {
    logic valid;
    out_t data;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/esht_ifs.sv
// ----------------------------------------------------------------------------
// esht item and result channels
// valid/ready channels for query items and hit results
// ----------------------------------------------------------------------------
`default_nettype none

interface esht_item_if;
  import esht_pkg::*;
  logic   valid;
  logic   ready;
  logic   command;
  coord_t first_x;
  coord_t first_y;
  coord_t second_x;
  coord_t second_y;
  modport source (output valid, command, first_x, first_y, second_x, second_y,
                  input ready);
  modport sink (input valid, command, first_x, first_y, second_x, second_y,
                output ready);
endinterface

interface esht_result_if;
  import esht_pkg::*;
  logic   valid;
  logic   ready;
  logic   hit;
  coord_t nearest_x;
  coord_t nearest_y;
  modport source (output valid, hit, nearest_x, nearest_y, input ready);
  modport sink (input valid, hit, nearest_x, nearest_y, output ready);
endinterface

`default_nettype wire

>>> rtl/ellipse_segment_hit_test.sv
// ----------------------------------------------------------------------------
// ellipse_segment_hit_test
// axis-aligned ellipse hit test for points and segments, Q16.16
// ----------------------------------------------------------------------------
// One query enters per clock unless the input is stalled; its result
// passes segment set-up (offsets, products, sums, end selection), the
// projection divider, which takes one multiplier bit per stage, the scaled
// hit test and one output register. A one-entry skid buffer behind the
// pipeline lets a new query enter while a result waits; the input stalls
// only when both output register and skid hold a result that has not been
// taken. Registers are written with write_enable, reg_index and write_data;
// the user must do so only with no query in flight; the block does not check.
`default_nettype none

module ellipse_segment_hit_test (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              write_enable,
  input  logic [esht_pkg::REG_IDX_W-1:0]    reg_index,
  input  esht_pkg::coord_t                  write_data,
  esht_item_if.sink                         item_in,
  esht_result_if.source                     result_out
);
  import esht_pkg::*;

  cfg_t      cfg;
  logic      en;
  div_item_t seg_item;
  point_t    div_pt;
  result_t   res;
  logic      ov, sv;
  out_t      od, sd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x <= '0;
      cfg.center_y <= '0;
      cfg.radius_x <= '0;
      cfg.radius_y <= '0;
      cfg.min_len  <= MIN_LEN_RESET;
    end else if (write_enable) begin
      unique case (reg_idx_t'(reg_index))
        REG_CENTER_X: cfg.center_x <= write_data;
        REG_CENTER_Y: cfg.center_y <= write_data;
        REG_RADIUS_X: cfg.radius_x <= write_data[COORD_WIDTH-2:0];
        REG_RADIUS_Y: cfg.radius_y <= write_data[COORD_WIDTH-2:0];
        REG_MIN_LEN:  cfg.min_len  <= write_data[COORD_WIDTH-2:0];
        default: ;
      endcase
    end
  end

  assign en            = !sv;
  assign item_in.ready = !sv;

  esht_seg u_seg (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .cfg      (cfg),
    .in_valid (item_in.valid),
    .in_cmd   (item_in.command),
    .in_x1    (item_in.first_x),
    .in_y1    (item_in.first_y),
    .in_x2    (item_in.second_x),
    .in_y2    (item_in.second_y),
    .item_out (seg_item)
  );

  esht_div u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .item_in (seg_item),
    .pt_out  (div_pt)
  );

  esht_hit u_hit (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .cfg     (cfg),
    .pt_in   (div_pt),
    .res_out (res)
  );

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (!sv) begin
      if (res.valid) begin
        if (!ov || result_out.ready) begin
          ov <= 1'b1;
        end else begin
          sv <= 1'b1;
        end
      end else if (result_out.ready) begin
        ov <= 1'b0;
      end
    end else if (result_out.ready) begin
      sv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!sv) begin
      if (res.valid && (!ov || result_out.ready)) begin
        od <= res.data;
      end else if (res.valid) begin
        sd <= res.data;
      end
    end else if (result_out.ready) begin
      od <= sd;
    end
  end

  assign result_out.valid     = ov;
  assign result_out.hit       = od.hit;
  assign result_out.nearest_x = od.x;
  assign result_out.nearest_y = od.y;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    sv |-> ov)
    else $error("skid holds a result while output register is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (sv && result_out.ready) |=> (!sv && ov))
    else $error("skid entry not moved on after transfer");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!ov && !sv))
    else $error("output stage not empty after reset");

endmodule

`default_nettype wire

>>> rtl/esht_seg.sv
// ----------------------------------------------------------------------------
// esht_seg
// segment front end: offsets, products, sums and end-point selection
// ----------------------------------------------------------------------------
`default_nettype none

module esht_seg (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  esht_pkg::cfg_t     cfg,
  input  logic               in_valid,
  input  logic               in_cmd,
  input  esht_pkg::coord_t   in_x1,
  input  esht_pkg::coord_t   in_y1,
  input  esht_pkg::coord_t   in_x2,
  input  esht_pkg::coord_t   in_y2,
  output esht_pkg::div_item_t item_out
);
  import esht_pkg::*;

  logic   s1_v, s2_v, s3_v;
  logic   s1_cmd, s2_cmd, s3_cmd;
  coord_t s1_x1, s1_y1, s1_x2, s1_y2;
  coord_t s2_x1, s2_y1, s2_x2, s2_y2;
  coord_t s3_x1, s3_y1, s3_x2, s3_y2;
  diff_t  s1_dx, s1_dy, s1_ax, s1_ay;
  diff_t  s2_dx, s2_dy, s3_dx, s3_dy;
  dot_t   s2_xx, s2_yy, s2_xp, s2_yp;
  len_t   s2_msl2, s3_msl2, s3_len;
  dot_t   s3_dot;

  logic   short_seg, before_start, past_end;
  sel_t   sel;
  diff_t  ndx, ndy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // offsets
      s1_cmd <= in_cmd;
      s1_x1  <= in_x1;
      s1_y1  <= in_y1;
      s1_x2  <= in_x2;
      s1_y2  <= in_y2;
      s1_dx  <= diff_t'(in_x2) - diff_t'(in_x1);
      s1_dy  <= diff_t'(in_y2) - diff_t'(in_y1);
      s1_ax  <= diff_t'(cfg.center_x) - diff_t'(in_x1);
      s1_ay  <= diff_t'(cfg.center_y) - diff_t'(in_y1);
      // products
      s2_cmd  <= s1_cmd;
      s2_x1   <= s1_x1;
      s2_y1   <= s1_y1;
      s2_x2   <= s1_x2;
      s2_y2   <= s1_y2;
      s2_dx   <= s1_dx;
      s2_dy   <= s1_dy;
      s2_xx   <= s1_dx * s1_dx;
      s2_yy   <= s1_dy * s1_dy;
      s2_xp   <= s1_ax * s1_dx;
      s2_yp   <= s1_ay * s1_dy;
      s2_msl2 <= len_t'(cfg.min_len) * len_t'(cfg.min_len);
      // sums
      s3_cmd  <= s2_cmd;
      s3_x1   <= s2_x1;
      s3_y1   <= s2_y1;
      s3_x2   <= s2_x2;
      s3_y2   <= s2_y2;
      s3_dx   <= s2_dx;
      s3_dy   <= s2_dy;
      s3_len  <= len_t'(s2_xx + s2_yy);
      s3_dot  <= s2_xp + s2_yp;
      s3_msl2 <= s2_msl2;
    end
  end

  always_comb begin
    short_seg    = s3_len <= s3_msl2;
    before_start = s3_dot < 0;
    past_end     = s3_dot > dot_t'(s3_len);
    if (!s3_cmd || short_seg || before_start) begin
      sel = SEL_FIRST;
    end else if (past_end) begin
      sel = SEL_SECOND;
    end else begin
      sel = SEL_INTERP;
    end
    ndx = -s3_dx;
    ndy = -s3_dy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_out.valid <= 1'b0;
    end else if (en) begin
      item_out.valid          <= s3_v;
      item_out.sel            <= sel;
      item_out.den            <= {s3_len, 1'b0};
      item_out.num            <= {s3_dot[LEN_W-1:0], 1'b0};
      item_out.lane[0].rem    <= '0;
      item_out.lane[0].quo    <= '0;
      item_out.lane[0].mag    <= s3_dx[COORD_WIDTH] ? ndx[MAG_W-1:0] : s3_dx[MAG_W-1:0];
      item_out.lane[0].neg    <= s3_dx[COORD_WIDTH];
      item_out.lane[0].first  <= s3_x1;
      item_out.lane[0].second <= s3_x2;
      item_out.lane[1].rem    <= '0;
      item_out.lane[1].quo    <= '0;
      item_out.lane[1].mag    <= s3_dy[COORD_WIDTH] ? ndy[MAG_W-1:0] : s3_dy[MAG_W-1:0];
      item_out.lane[1].neg    <= s3_dy[COORD_WIDTH];
      item_out.lane[1].first  <= s3_y1;
      item_out.lane[1].second <= s3_y2;
    end
  end

endmodule

`default_nettype wire

>>> rtl/esht_div.sv
// ----------------------------------------------------------------------------
// esht_div
// pipelined projection divider, one multiplier bit per stage, both axes
// ----------------------------------------------------------------------------
`default_nettype none

module esht_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  esht_pkg::div_item_t item_in,
  output esht_pkg::point_t    pt_out
);
  import esht_pkg::*;

  function automatic lane_t lane_step(lane_t l, den_t den, den_t num);
    rem_t     t;
    rem_t     d1;
    rem_t     d2;
    logic [1:0] dig;
    lane_t    o;
    o  = l;
    d1 = rem_t'(den);
    d2 = {d1[REM_W-2:0], 1'b0};
    t  = {l.rem[REM_W-2:0], 1'b0} + (l.mag[MAG_W-1] ? rem_t'(num) : '0);
    if (t >= d2) begin
      o.rem = t - d2;
      dig   = 2'd2;
    end else if (t >= d1) begin
      o.rem = t - d1;
      dig   = 2'd1;
    end else begin
      o.rem = t;
      dig   = 2'd0;
    end
    o.quo = {l.quo[MAG_W-2:0], 1'b0} + mag_t'(dig);
    o.mag = {l.mag[MAG_W-2:0], 1'b0};
    return o;
  endfunction

  function automatic div_item_t div_step(div_item_t s);
    div_item_t o;
    o         = s;
    o.lane[0] = lane_step(s.lane[0], s.den, s.num);
    o.lane[1] = lane_step(s.lane[1], s.den, s.num);
    return o;
  endfunction

  // rounding half step, then first end plus or minus the quotient, or either end as selected
  function automatic coord_t lane_final(lane_t l, den_t den, sel_t sel);
    rem_t   t;
    mag_t   q;
    diff_t  s;
    coord_t r;
    t = l.rem + rem_t'(den >> 1);
    q = l.quo + mag_t'(t >= rem_t'(den));
    s = l.neg ? diff_t'(l.first) - diff_t'({1'b0, q})
              : diff_t'(l.first) + diff_t'({1'b0, q});
    case (sel)
      SEL_SECOND: r = l.second;
      SEL_INTERP: r = s[COORD_WIDTH-1:0];
      default:    r = l.first;
    endcase
    return r;
  endfunction

  div_item_t st [1:MAG_W];

  for (genvar k = 1; k <= MAG_W; k++) begin : g_step
    div_item_t prev;
    if (k == 1) begin : g_first
      assign prev = item_in;
    end else begin : g_next
      assign prev = st[k-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        st[k].valid <= 1'b0;
      end else if (en) begin
        st[k] <= div_step(prev);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_out.valid <= 1'b0;
    end else if (en) begin
      pt_out.valid <= st[MAG_W].valid;
      pt_out.x     <= lane_final(st[MAG_W].lane[0], st[MAG_W].den, st[MAG_W].sel);
      pt_out.y     <= lane_final(st[MAG_W].lane[1], st[MAG_W].den, st[MAG_W].sel);
    end
  end

endmodule

`default_nettype wire

>>> rtl/esht_hit.sv
// ----------------------------------------------------------------------------
// esht_hit
// scaled ellipse test: offsets, products, split squares, sum and compare
// ----------------------------------------------------------------------------
`default_nettype none

module esht_hit (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  esht_pkg::cfg_t    cfg,
  input  esht_pkg::point_t  pt_in,
  output esht_pkg::result_t res_out
);
  import esht_pkg::*;

  localparam int HALF = COORD_WIDTH;

  logic    h1_v, h2_v, h3_v, h4_v, h5_v;
  logic    h1_zero, h2_zero, h3_zero, h4_zero, h5_zero;
  coord_t  h1_x, h1_y, h2_x, h2_y, h3_x, h3_y, h4_x, h4_y, h5_x, h5_y;
  mag_t    h1_ux, h1_uy;
  radius_t h1_kx, h1_ky, h1_minor, h1_major;
  prod_t   h2_a, h2_b, h2_c;
  prod_t   h3_ahh, h3_ahl, h3_all;
  prod_t   h3_bhh, h3_bhl, h3_bll;
  prod_t   h3_chh, h3_chl, h3_cll;
  sq_t     h4_a2, h4_b2, h4_c2;
  logic [SQ_W:0] h5_s;
  sq_t     h5_c2;

  diff_t   ox, oy, nox, noy;
  mag_t    ux, uy;
  radius_t major, minor, kx, ky;

  always_comb begin
    ox  = diff_t'(pt_in.x) - diff_t'(cfg.center_x);
    oy  = diff_t'(pt_in.y) - diff_t'(cfg.center_y);
    nox = -ox;
    noy = -oy;
    ux  = ox[COORD_WIDTH] ? nox[MAG_W-1:0] : ox[MAG_W-1:0];
    uy  = oy[COORD_WIDTH] ? noy[MAG_W-1:0] : oy[MAG_W-1:0];
    if (cfg.radius_y > cfg.radius_x) begin
      major = cfg.radius_y;
      minor = cfg.radius_x;
    end else begin
      major = cfg.radius_x;
      minor = cfg.radius_y;
    end
    kx = (major == cfg.radius_x) ? minor : major;
    ky = (major == cfg.radius_y) ? minor : major;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h1_v      <= 1'b0;
      h2_v      <= 1'b0;
      h3_v      <= 1'b0;
      h4_v      <= 1'b0;
      h5_v      <= 1'b0;
      res_out.valid <= 1'b0;
    end else if (en) begin
      h1_v      <= pt_in.valid;
      h2_v      <= h1_v;
      h3_v      <= h2_v;
      h4_v      <= h3_v;
      h5_v      <= h4_v;
      res_out.valid <= h5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // offsets and axis weights
      h1_x     <= pt_in.x;
      h1_y     <= pt_in.y;
      h1_ux    <= ux;
      h1_uy    <= uy;
      h1_kx    <= kx;
      h1_ky    <= ky;
      h1_minor <= minor;
      h1_major <= major;
      h1_zero  <= major == '0;
      // scaled offsets
      h2_x    <= h1_x;
      h2_y    <= h1_y;
      h2_zero <= h1_zero;
      h2_a    <= h1_ux * h1_kx;
      h2_b    <= h1_uy * h1_ky;
      h2_c    <= h1_minor * h1_major;
      // square partial products
      h3_x    <= h2_x;
      h3_y    <= h2_y;
      h3_zero <= h2_zero;
      h3_ahh  <= prod_t'(h2_a[PROD_W-1:HALF]) * prod_t'(h2_a[PROD_W-1:HALF]);
      h3_ahl  <= prod_t'(h2_a[PROD_W-1:HALF]) * prod_t'(h2_a[HALF-1:0]);
      h3_all  <= prod_t'(h2_a[HALF-1:0]) * prod_t'(h2_a[HALF-1:0]);
      h3_bhh  <= prod_t'(h2_b[PROD_W-1:HALF]) * prod_t'(h2_b[PROD_W-1:HALF]);
      h3_bhl  <= prod_t'(h2_b[PROD_W-1:HALF]) * prod_t'(h2_b[HALF-1:0]);
      h3_bll  <= prod_t'(h2_b[HALF-1:0]) * prod_t'(h2_b[HALF-1:0]);
      h3_chh  <= prod_t'(h2_c[PROD_W-1:HALF]) * prod_t'(h2_c[PROD_W-1:HALF]);
      h3_chl  <= prod_t'(h2_c[PROD_W-1:HALF]) * prod_t'(h2_c[HALF-1:0]);
      h3_cll  <= prod_t'(h2_c[HALF-1:0]) * prod_t'(h2_c[HALF-1:0]);
      // squares
      h4_x    <= h3_x;
      h4_y    <= h3_y;
      h4_zero <= h3_zero;
      h4_a2   <= {h3_ahh, h3_all} + (sq_t'(h3_ahl) << (HALF + 1));
      h4_b2   <= {h3_bhh, h3_bll} + (sq_t'(h3_bhl) << (HALF + 1));
      h4_c2   <= {h3_chh, h3_cll} + (sq_t'(h3_chl) << (HALF + 1));
      // sum
      h5_x    <= h4_x;
      h5_y    <= h4_y;
      h5_zero <= h4_zero;
      h5_s    <= {1'b0, h4_a2} + {1'b0, h4_b2};
      h5_c2   <= h4_c2;
      // compare
      res_out.data.x   <= h5_x;
      res_out.data.y   <= h5_y;
      res_out.data.hit <= !h5_zero && (h5_s <= {1'b0, h5_c2});
    end
  end

endmodule

`default_nettype wire

>>> dv/ellipse_segment_hit_test_tb.sv
// ----------------------------------------------------------------------------
// ellipse_segment_hit_test_tb
// self-checking bench: directed and random point and segment queries under
// several ellipse settings, random idling on both channels and one long
// receiver hold-off; every result is compared with a wide-integer predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ellipse_segment_hit_test_tb;
  import esht_pkg::*;

  typedef logic signed [255:0] big_t;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 60;

  class hit_scoreboard;
    coord_t  cx, cy;
    radius_t rx, ry, min_len;
    out_t    pending_q[$];
    int      errors;

    function new();
      cx = '0; cy = '0; rx = '0; ry = '0; min_len = MIN_LEN_RESET; errors = 0;
    endfunction

    function void set_reg(reg_idx_t idx, coord_t v);
      case (idx)
        REG_CENTER_X: cx = v;
        REG_CENTER_Y: cy = v;
        REG_RADIUS_X: rx = v[COORD_WIDTH-2:0];
        REG_RADIUS_Y: ry = v[COORD_WIDTH-2:0];
        REG_MIN_LEN:  min_len = v[COORD_WIDTH-2:0];
        default: ;
      endcase
    endfunction

    function bit in_ellipse(big_t px, big_t py);
      big_t brx, bry, major, minor, kx, ky, dx, dy, lhs, rhs;
      brx = big_t'({1'b0, rx});
      bry = big_t'({1'b0, ry});
      major = (bry > brx) ? bry : brx;
      minor = (bry > brx) ? brx : bry;
      if (major == 0) return 1'b0;
      kx = (major == brx) ? minor : major;
      ky = (major == bry) ? minor : major;
      dx = px - big_t'(cx);
      dy = py - big_t'(cy);
      lhs = dx * dx * kx * kx + dy * dy * ky * ky;
      rhs = minor * minor * major * major;
      return lhs <= rhs;
    endfunction

    function big_t project_axis(big_t first, big_t d, big_t dot, big_t len2);
      big_t mag, q;
      mag = (d < 0) ? -d : d;
      q = (2 * mag * dot + len2) / (2 * len2);
      return (d < 0) ? first - q : first + q;
    endfunction

    function void note_item(bit cmd, coord_t x1, coord_t y1, coord_t x2, coord_t y2);
      big_t bx1, by1, bx2, by2, dx, dy, len2, dot, ml, px, py;
      out_t o;
      bx1 = big_t'(x1); by1 = big_t'(y1); bx2 = big_t'(x2); by2 = big_t'(y2);
      px = bx1; py = by1;
      if (cmd) begin
        dx = bx2 - bx1;
        dy = by2 - by1;
        len2 = dx * dx + dy * dy;
        dot = (big_t'(cx) - bx1) * dx + (big_t'(cy) - by1) * dy;
        ml = big_t'({1'b0, min_len});
        if (len2 <= ml * ml || dot < 0) begin
          px = bx1; py = by1;
        end else if (dot > len2) begin
          px = bx2; py = by2;
        end else begin
          px = project_axis(bx1, dx, dot, len2);
          py = project_axis(by1, dy, dot, len2);
        end
      end
      o.hit = in_ellipse(px, py);
      o.x = coord_t'(px);
      o.y = coord_t'(py);
      pending_q.push_back(o);
    endfunction

    function void check_result(logic hit, coord_t x, coord_t y);
      out_t e;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: hit %0b x %h y %h", hit, x, y);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (hit !== e.hit) begin
        $error("hit: expected %0b actual %0b", e.hit, hit); errors++;
      end
      if (x !== e.x) begin
        $error("nearest_x: expected %h actual %h", e.x, x); errors++;
      end
      if (y !== e.y) begin
        $error("nearest_y: expected %h actual %h", e.y, y); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic write_enable;
  logic [REG_IDX_W-1:0] reg_index;
  coord_t write_data;
  bit calm;
  int cycles;

  esht_item_if item_bus ();
  esht_result_if result_bus ();

  hit_scoreboard sb;

  ellipse_segment_hit_test dut (
    .clk(clk),
    .rst(rst),
    .write_enable(write_enable),
    .reg_index(reg_index),
    .write_data(write_data),
    .item_in(item_bus),
    .result_out(result_bus)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // cycle limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // result side, with one long hold-off to back the pipeline up
  initial begin
    int rx_cycles;
    int hold;
    rx_cycles = 0;
    hold = 0;
    result_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        rx_cycles++;
        if (result_bus.valid && result_bus.ready)
          sb.check_result(result_bus.hit, result_bus.nearest_x, result_bus.nearest_y);
        if (rx_cycles == 1500) hold = 300;
        if (hold > 0) begin
          hold--;
          result_bus.ready <= 1'b0;
        end else begin
          result_bus.ready <= calm || ($urandom_range(99) >= 37);
        end
      end
    end
  end

  task automatic write_all(coord_t cx, coord_t cy, radius_t rx, radius_t ry, radius_t ml);
    coord_t vals[5];
    vals[0] = cx; vals[1] = cy; vals[2] = {1'b0, rx}; vals[3] = {1'b0, ry};
    vals[4] = {1'b0, ml};
    item_bus.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    for (int i = 0; i < 5; i++) begin
      write_enable <= 1'b1;
      reg_index <= REG_IDX_W'(i);
      write_data <= vals[i];
      sb.set_reg(reg_idx_t'(i), vals[i]);
      @(posedge clk);
    end
    write_enable <= 1'b0;
  endtask

  task automatic send_query(bit cmd, coord_t x1, coord_t y1, coord_t x2, coord_t y2);
    if (!calm && $urandom_range(99) < 37) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    item_bus.valid <= 1'b1;
    item_bus.command <= cmd;
    item_bus.first_x <= x1;
    item_bus.first_y <= y1;
    item_bus.second_x <= x2;
    item_bus.second_y <= y2;
    do @(posedge clk); while (!item_bus.ready);
    sb.note_item(cmd, x1, y1, x2, y2);
  endtask

  function automatic coord_t near_center(coord_t c, radius_t r1, radius_t r2);
    longint span, off;
    span = 3 * longint'((r1 > r2) ? r1 : r2) + 16;
    if (span > 64'h3fff_ffff) span = 64'h3fff_ffff;
    off = longint'($urandom_range(0, 32'(2 * span))) - span;
    return coord_t'(longint'(c) + off);
  endfunction

  task automatic send_random();
    bit cmd;
    coord_t x1, y1, x2, y2;
    cmd = 1'($urandom_range(1));
    if ($urandom_range(9) < 2) begin
      x1 = $urandom; y1 = $urandom; x2 = $urandom; y2 = $urandom;
    end else begin
      x1 = near_center(sb.cx, sb.rx, sb.ry);
      y1 = near_center(sb.cy, sb.rx, sb.ry);
      x2 = near_center(sb.cx, sb.rx, sb.ry);
      y2 = near_center(sb.cy, sb.rx, sb.ry);
      if ($urandom_range(9) == 0) begin
        x2 = x1 + coord_t'($urandom_range(3)); y2 = y1;
      end
    end
    send_query(cmd, x1, y1, x2, y2);
  endtask

  localparam coord_t ONE  = 32'h0001_0000;
  localparam coord_t CMIN = 32'h8000_0000;
  localparam coord_t CMAX = 32'h7fff_ffff;
  localparam radius_t RMAX = 31'h7fff_ffff;

  initial begin
    sb = new();
    calm = 1'b0;
    rst = 1'b1;
    write_enable = 1'b0;
    reg_index = '0;
    write_data = '0;
    item_bus.valid = 1'b0;
    item_bus.command = 1'b0;
    item_bus.first_x = '0;
    item_bus.first_y = '0;
    item_bus.second_x = '0;
    item_bus.second_y = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: both radii zero never hit
    send_query(1'b0, '0, '0, '0, '0);
    send_query(1'b1, -ONE, '0, ONE, '0);

    write_all('0, '0, radius_t'(2 * ONE), radius_t'(ONE), MIN_LEN_RESET);
    send_query(1'b0, '0, '0, CMAX, CMIN);
    send_query(1'b0, 2 * ONE, '0, '0, '0);
    send_query(1'b0, 2 * ONE + 1, '0, '0, '0);
    send_query(1'b0, '0, ONE, '0, '0);
    send_query(1'b0, '0, -ONE - 1, '0, '0);
    send_query(1'b1, -5 * ONE, -ONE, 5 * ONE, ONE);
    send_query(1'b1, ONE, ONE, 4 * ONE, 3 * ONE);
    send_query(1'b1, -4 * ONE, -3 * ONE, -ONE, -ONE);
    send_query(1'b1, 3 * ONE, 3 * ONE, 3 * ONE, 3 * ONE);
    send_query(1'b1, -2 * ONE, '0, -2 * ONE + 100, 5);
    send_query(1'b1, -3, 1, 3, 2);
    send_query(1'b1, CMIN, CMIN, CMAX, CMAX);
    send_query(1'b1, CMAX, CMIN, CMIN, CMAX);
    send_query(1'b0, CMIN, CMAX, '0, '0);

    write_all(CMIN, CMAX, RMAX, RMAX, RMAX);
    send_query(1'b0, CMIN, CMAX, '0, '0);
    send_query(1'b0, CMAX, CMIN, '0, '0);
    send_query(1'b1, CMAX, CMAX, CMIN, CMIN);

    write_all(ONE, -ONE, '0, radius_t'(3 * ONE), '0);
    send_query(1'b0, ONE, ONE, '0, '0);
    send_query(1'b0, ONE + 1, ONE, '0, '0);
    send_query(1'b1, -ONE, -ONE, 3 * ONE, -ONE);
    send_query(1'b1, '0, '0, 1, '0);

    write_all(coord_t'($urandom_range(0, 1 << 21)) - (1 << 20),
              coord_t'($urandom_range(0, 1 << 21)) - (1 << 20),
              radius_t'($urandom_range(1 << 10, 1 << 20)),
              radius_t'($urandom_range(1 << 10, 1 << 20)),
              radius_t'($urandom_range(0, 1 << 12)));
    repeat (220) send_random();

    write_all(coord_t'($urandom), coord_t'($urandom),
              radius_t'(5 * ONE), radius_t'(5 * ONE), '0);
    calm = 1'b1;
    repeat (100) send_random();
    calm = 1'b0;
    repeat (100) send_random();

    write_all(CMIN, CMAX, RMAX, RMAX, RMAX);
    repeat (180) send_random();

    write_all(coord_t'($urandom), coord_t'($urandom), '0,
              radius_t'($urandom_range(1, 1 << 22)),
              radius_t'($urandom_range(0, 1 << 16)));
    repeat (200) send_random();

    item_bus.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
